[rtl/lsbse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lsbse_pkg;

  localparam int MSG_DEPTH_DEF = 1024;
  localparam int HEADER_BITS   = 32;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LENGTH = 1'd1;

  localparam logic DIR_EMBED   = 1'b0;
  localparam logic DIR_EXTRACT = 1'b1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 3;

  typedef struct packed {
    logic done;
    logic length_valid;
    logic byte_valid;
  } out_flags_t;

endpackage

`default_nettype wire

[rtl/lsbse_msg_buf.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsbse_msg_buf #(
  parameter int DEPTH = lsbse_pkg::MSG_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output      logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;
  logic [7:0] fwd_data_r;
  logic       fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r  <= mem[rd_addr];
    fwd_data_r <= wr_data;
  end

  // same-cycle write to the entry being read: pass new data through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_data_r;

endmodule

`default_nettype wire

[rtl/lsb_stego_embed_extract_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// An accepted pixel's result is in the output register in the next cycle.
// Throughput: one item per cycle (load or pixel) unless the output stalls;
// loads give no result. The buffer read is prefetched from the next walk state.
// Reset (rst_n low, synchronous): direction embed, length 0, walk restarted,
// write pointer 0, output empty. Buffer contents undefined until loaded.
module lsb_stego_embed_extract_unit #(
  parameter int MSG_DEPTH = lsbse_pkg::MSG_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // [0] mode, [1] first
  input  wire logic [lsbse_pkg::IN_USER_W-1:0]     in_tuser,
  // [7:0] data_byte, [15:8] red, [23:16] green, [31:24] blue
  input  wire logic [lsbse_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  // [0] byte_valid, [1] length_valid, [2] message_done
  output      logic [lsbse_pkg::OUT_USER_W-1:0]    out_tuser,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out,
  // [31:24] message_byte, [63:32] found_length
  output      logic [lsbse_pkg::OUT_DATA_W-1:0]    out_tdata,
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [lsbse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lsbse_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MSG_DEPTH);
  localparam int CW = $clog2(MSG_DEPTH + 1);
  localparam logic [31:0] DEPTH32 = 32'(MSG_DEPTH);
  localparam logic [5:0]  HDR6    = 6'(lsbse_pkg::HEADER_BITS);

  // config
  logic        direction_r;
  logic [10:0] msg_len_r;

  // walk state
  logic [1:0]    cs_r, cs_nxt;
  logic [5:0]    hb_r, hb_nxt;
  logic [CW-1:0] bi_r, bi_nxt;
  logic [2:0]    bb_r, bb_nxt;
  logic [31:0]   sr_r, sr_nxt;
  logic [31:0]   el_r, el_nxt;
  logic [CW-1:0] wp_r, wp_nxt;

  // output register
  logic                                  out_valid_r, out_valid_nxt;
  logic [lsbse_pkg::OUT_DATA_W-1:0]      out_data_r, out_data_nxt;
  lsbse_pkg::out_flags_t                 out_flags_r, out_flags_nxt;

  // buffer port
  logic          buf_we;
  logic [AW-1:0] buf_wa;
  logic [AW-1:0] buf_ra;
  logic [7:0]    buf_rd;

  logic in_acc;
  logic mode, first;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign mode       = in_tuser[0];
  assign first      = in_tuser[1];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flags_r;

  lsbse_msg_buf #(
    .DEPTH (MSG_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (buf_we),
    .wr_addr (buf_wa),
    .wr_data (in_tdata[7:0]),
    .rd_addr (buf_ra),
    .rd_data (buf_rd)
  );

  always_comb begin
    logic [1:0]    cs_e, ch;
    logic [5:0]    hb_e;
    logic [CW-1:0] bi_e, len, elc;
    logic [2:0]    bb_e;
    logic [31:0]   sr_e, el_e, len32, sr_sh;
    logic [CW-1:0] wp_e;
    logic [4:0]    sh;
    logic          bit_emb, do_emb, lsb;
    logic [7:0]    r_i, g_i, b_i, r_o, g_o, b_o, mb;
    logic          bv, lv, done;

    cs_nxt  = cs_r;
    hb_nxt  = hb_r;
    bi_nxt  = bi_r;
    bb_nxt  = bb_r;
    sr_nxt  = sr_r;
    el_nxt  = el_r;
    wp_nxt  = wp_r;
    buf_we  = 1'b0;
    buf_wa  = '0;

    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_flags_nxt = out_flags_r;

    r_i = in_tdata[15:8];
    g_i = in_tdata[23:16];
    b_i = in_tdata[31:24];
    r_o = r_i;
    g_o = g_i;
    b_o = b_i;

    cs_e = first ? lsbse_pkg::CH_RED : cs_r;
    hb_e = first ? HDR6 : hb_r;
    bi_e = first ? '0 : bi_r;
    bb_e = first ? 3'd0 : bb_r;
    sr_e = first ? 32'd0 : sr_r;
    el_e = first ? 32'd0 : el_r;
    ch   = (cs_e > lsbse_pkg::CH_BLUE) ? lsbse_pkg::CH_RED : cs_e;

    len32 = (32'(msg_len_r) > DEPTH32) ? DEPTH32 : 32'(msg_len_r);
    len   = len32[CW-1:0];
    elc   = (el_e > DEPTH32) ? DEPTH32[CW-1:0] : el_e[CW-1:0];

    case (ch)
      lsbse_pkg::CH_GREEN: lsb = g_i[0];
      lsbse_pkg::CH_BLUE:  lsb = b_i[0];
      default:             lsb = r_i[0];
    endcase

    sh      = 5'(hb_e - 6'd1);
    sr_sh   = {sr_e[30:0], lsb};
    bit_emb = 1'b0;
    do_emb  = 1'b0;
    bv      = 1'b0;
    lv      = 1'b0;
    done    = 1'b0;
    mb      = 8'd0;
    wp_e    = first ? '0 : wp_r;

    if (in_acc && mode == lsbse_pkg::MODE_LOAD) begin
      if (32'(wp_e) < DEPTH32) begin
        buf_we = 1'b1;
        buf_wa = wp_e[AW-1:0];
        wp_nxt = wp_e + 1'b1;
      end else begin
        wp_nxt = wp_e;
      end
    end

    if (in_acc && mode == lsbse_pkg::MODE_PIXEL) begin
      cs_nxt = hb_e == 6'd0 ? cs_e : cs_e;
      hb_nxt = hb_e;
      bi_nxt = bi_e;
      bb_nxt = bb_e;
      sr_nxt = sr_e;
      el_nxt = el_e;
      if (direction_r == lsbse_pkg::DIR_EMBED) begin
        if (hb_e != 6'd0) begin
          do_emb  = 1'b1;
          bit_emb = len32[sh];
          hb_nxt  = hb_e - 6'd1;
          done    = (hb_e == 6'd1) && (len == '0);
        end else if (bi_e < len) begin
          do_emb  = 1'b1;
          bit_emb = buf_rd[~bb_e];
          bb_nxt  = bb_e + 3'd1;
          if (bb_e == 3'd7) begin
            bi_nxt = bi_e + 1'b1;
          end
          done = (bi_nxt >= len);
        end else begin
          done = 1'b1;
        end
      end else begin
        if (hb_e != 6'd0) begin
          sr_nxt = sr_sh;
          hb_nxt = hb_e - 6'd1;
          if (hb_e == 6'd1) begin
            el_nxt = sr_sh;
            sr_nxt = 32'd0;
            lv     = 1'b1;
            done   = (sr_sh == 32'd0);
          end
        end else if (bi_e < elc) begin
          sr_nxt = {24'd0, sr_sh[7:0]};
          bb_nxt = bb_e + 3'd1;
          if (bb_e == 3'd7) begin
            bv     = 1'b1;
            mb     = sr_sh[7:0];
            sr_nxt = 32'd0;
            bi_nxt = bi_e + 1'b1;
            done   = (bi_e + 1'b1 >= elc);
          end
        end else begin
          done = 1'b1;
        end
      end
      cs_nxt = (ch == lsbse_pkg::CH_BLUE) ? lsbse_pkg::CH_RED : ch + 2'd1;

      r_o = (do_emb && ch == lsbse_pkg::CH_RED)   ? {r_i[7:1], bit_emb} : r_i;
      g_o = (do_emb && ch == lsbse_pkg::CH_GREEN) ? {g_i[7:1], bit_emb} : g_i;
      b_o = (do_emb && ch == lsbse_pkg::CH_BLUE)  ? {b_i[7:1], bit_emb} : b_i;

      out_valid_nxt = 1'b1;
      out_data_nxt  = {(direction_r == lsbse_pkg::DIR_EXTRACT) ? el_nxt : 32'd0,
                       mb, b_o, g_o, r_o};
      out_flags_nxt.byte_valid   = bv;
      out_flags_nxt.length_valid = lv;
      out_flags_nxt.done         = done;
    end

    // prefetch the byte the next pixel may need
    buf_ra = (32'(bi_nxt) < DEPTH32) ? bi_nxt[AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= lsbse_pkg::DIR_EMBED;
      msg_len_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsbse_pkg::CFG_DIRECTION:  direction_r <= cfg_data[0];
        lsbse_pkg::CFG_MSG_LENGTH: msg_len_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r        <= lsbse_pkg::CH_RED;
      hb_r        <= HDR6;
      bi_r        <= '0;
      bb_r        <= 3'd0;
      sr_r        <= 32'd0;
      el_r        <= 32'd0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
      out_flags_r <= '0;
    end else begin
      cs_r        <= cs_nxt;
      hb_r        <= hb_nxt;
      bi_r        <= bi_nxt;
      bb_r        <= bb_nxt;
      sr_r        <= sr_nxt;
      el_r        <= el_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
      out_flags_r <= out_flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
